// File: sv/matrix4x4_multiply_scale_unit_defines.svh
// ============================================================================
// Matrix unit assertion macros
// Shared assertion helpers for the 4x4 fixed-point matrix unit.
// ============================================================================
`ifndef MATRIX4X4_MULTIPLY_SCALE_UNIT_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_SCALE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAT4_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAT4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mat4_pkg.sv
// ============================================================================
// Matrix unit package
// Operation codes, widths and the pipeline tag of the 4x4 matrix unit.
// ============================================================================
`default_nettype none

package mat4_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 4;
    localparam int unsigned PROD_W = 2 * DATA_W;
    // Four products summed need two further bits.
    localparam int unsigned ACC_W  = PROD_W + 2;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned CNT_W  = 6;

    typedef enum logic [1:0] {
        FUNC_WR_LEFT  = 2'd0,
        FUNC_WR_RIGHT = 2'd1,
        FUNC_MULTIPLY = 2'd2,
        FUNC_SCALE    = 2'd3
    } func_t;

    // Travels with each memory read down the pipeline.
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } tag_t;

endpackage

`default_nettype wire

// File: sv/matrix4x4_multiply_scale_unit.sv
// ============================================================================
// 4x4 fixed-point matrix multiply and scale unit
// Holds a left and a right Q16.16 matrix in small synchronous memories and
// emits left*right or left*scalar, floored and saturated, one run at a time.
// ============================================================================
//
//  Channel   Signals                                   Transfer when
//  -------   ---------------------------------------   -----------------------
//  command   start, busy, func, elem_index, value      start high, busy low
//  result    strobe, out_index, out_value, last        strobe high
//
// A load command writes one element and leaves busy low. A multiply command
// keeps busy high while it issues its reads, one per product term, and until
// the last sum has passed the read register, the product register and the
// accumulator. A scale command does the same with one read per element.
// The last result appears in the cycle busy falls, so the next command can
// be given while that result is shown. A multiply gives one result per four
// product terms, a scale its results in consecutive cycles; the receiver
// cannot stall them.
// Reset clears both matrices at once through per-entry valid bits.
//
`default_nettype none

module matrix4x4_multiply_scale_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire mat4_pkg::func_t                  func,
    input  wire logic [mat4_pkg::IDX_W-1:0]       elem_index,
    input  wire logic signed [mat4_pkg::DATA_W-1:0] value,
    output logic                                  strobe,
    output logic [mat4_pkg::IDX_W-1:0]            out_index,
    output logic signed [mat4_pkg::DATA_W-1:0]   out_value,
    output logic                                  last
);

    import mat4_pkg::*;

    localparam int unsigned DEPTH = 1 << IDX_W;
    localparam int unsigned SH_W  = ACC_W - FRAC_W;

    // Control state.
    logic               busy_reg, busy_next;
    logic               iss_reg, iss_next;
    logic               mode_reg, mode_next;   // 1 for multiply, 0 for scale
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DATA_W-1:0]  scalar_reg;

    // Matrix memories and their valid bits.
    logic [DATA_W-1:0]  left_mem  [DEPTH];
    logic [DATA_W-1:0]  right_mem [DEPTH];
    logic [DEPTH-1:0]   left_vld_reg;
    logic [DEPTH-1:0]   right_vld_reg;
    logic [DATA_W-1:0]  left_rd_reg;
    logic [DATA_W-1:0]  right_rd_reg;
    logic               left_rdv_reg;
    logic               right_rdv_reg;

    // Pipeline.
    tag_t                     tag0, tag1_reg, tag2_reg, tag3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     strobe_reg;
    logic [IDX_W-1:0]         out_index_reg;
    logic [DATA_W-1:0]        out_value_reg;
    logic                     last_reg;

    logic               accept;
    logic               wr_left;
    logic               wr_right;
    logic               start_run;
    logic               issue_end;
    logic [IDX_W-1:0]   left_addr;
    logic [IDX_W-1:0]   right_addr;
    logic [1:0]         row, col, term;
    logic [DATA_W-1:0]  op_a;
    logic [DATA_W-1:0]  op_b;
    logic [SH_W-1:0]    shifted;
    logic [DATA_W-1:0]  sat_value;
    logic               tag3_final;

    assign accept = start && !busy_reg;

    always_comb
    begin
        wr_left   = 1'b0;
        wr_right  = 1'b0;
        start_run = 1'b0;
        case (func)
            FUNC_WR_LEFT:  wr_left   = accept;
            FUNC_WR_RIGHT: wr_right  = accept;
            FUNC_MULTIPLY: start_run = accept;
            FUNC_SCALE:    start_run = accept;
            default:       start_run = 1'b0;
        endcase
    end

    // Multiply walks row, column, then term; scale walks the element index.
    assign row  = cnt_reg[5:4];
    assign col  = cnt_reg[3:2];
    assign term = cnt_reg[1:0];

    always_comb
    begin
        if (mode_reg)
        begin
            left_addr  = {row, term};
            right_addr = {term, col};
            tag0.first = (term == 2'd0);
            tag0.last  = (term == 2'd3);
            tag0.idx   = {row, col};
            issue_end  = (cnt_reg == CNT_W'(DEPTH * 4 - 1));
        end
        else
        begin
            left_addr  = cnt_reg[IDX_W-1:0];
            right_addr = cnt_reg[IDX_W-1:0];
            tag0.first = 1'b1;
            tag0.last  = 1'b1;
            tag0.idx   = cnt_reg[IDX_W-1:0];
            issue_end  = (cnt_reg[IDX_W-1:0] == IDX_W'(DEPTH - 1));
        end
        tag0.vld = iss_reg;
    end

    assign tag3_final = tag3_reg.vld && tag3_reg.last && (tag3_reg.idx == IDX_W'(DEPTH - 1));

    always_comb
    begin
        busy_next = busy_reg;
        iss_next  = iss_reg;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        if (start_run)
        begin
            busy_next = 1'b1;
            iss_next  = 1'b1;
            mode_next = (func == FUNC_MULTIPLY);
            cnt_next  = '0;
        end
        else if (iss_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (issue_end)
            begin
                iss_next = 1'b0;
            end
        end
        // The final sum leaves the accumulator: the run is complete.
        if (tag3_final)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            iss_reg       <= 1'b0;
            mode_reg      <= 1'b0;
            cnt_reg       <= '0;
            left_vld_reg  <= '0;
            right_vld_reg <= '0;
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            tag3_reg      <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            iss_reg    <= iss_next;
            mode_reg   <= mode_next;
            cnt_reg    <= cnt_next;
            tag1_reg   <= tag0;
            tag2_reg   <= tag1_reg;
            tag3_reg   <= tag2_reg;
            strobe_reg <= tag3_reg.vld && tag3_reg.last;
            if (wr_left)
            begin
                left_vld_reg[elem_index] <= 1'b1;
            end
            if (wr_right)
            begin
                right_vld_reg[elem_index] <= 1'b1;
            end
        end
    end

    // Memories: one write and one registered read per cycle each. Writes only
    // happen while idle; the reads run every cycle but are used only during a run.
    always_ff @(posedge clk)
    begin
        if (wr_left)
        begin
            left_mem[elem_index] <= value;
        end
        if (wr_right)
        begin
            right_mem[elem_index] <= value;
        end
        left_rd_reg   <= left_mem[left_addr];
        right_rd_reg  <= right_mem[right_addr];
        left_rdv_reg  <= left_vld_reg[left_addr];
        right_rdv_reg <= right_vld_reg[right_addr];
    end

    // An entry never written since reset reads as zero.
    assign op_a = left_rdv_reg ? left_rd_reg : '0;
    assign op_b = mode_reg ? (right_rdv_reg ? right_rd_reg : '0) : scalar_reg;

    // Floor division by 2^16 is an arithmetic shift of the exact sum.
    assign shifted = acc_reg[ACC_W-1:FRAC_W];

    always_comb
    begin
        if ((&shifted[SH_W-1:DATA_W-1]) || !(|shifted[SH_W-1:DATA_W-1]))
        begin
            sat_value = shifted[DATA_W-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            sat_value = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_run)
        begin
            scalar_reg <= value;
        end
        prod_reg <= $signed(op_a) * $signed(op_b);
        if (tag2_reg.first)
        begin
            acc_reg <= ACC_W'(prod_reg);
        end
        else
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        out_index_reg <= tag3_reg.idx;
        out_value_reg <= sat_value;
        last_reg      <= tag3_final;
    end

    assign busy      = busy_reg;
    assign strobe    = strobe_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign last      = strobe_reg && last_reg;

`include "matrix4x4_multiply_scale_unit_defines.svh"

    `MAT4_ASSERT_NEXT(a_run_sets_busy, clk, rst_n, start_run, busy_reg, "run did not raise busy")
    `MAT4_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, wr_left || wr_right, !busy_reg, "load raised busy")
    `MAT4_ASSERT_SAME(a_last_index, clk, rst_n, strobe && last, out_index == IDX_W'(DEPTH - 1), "last on wrong index")
    `MAT4_ASSERT_SAME(a_last_idle, clk, rst_n, strobe && last, !busy_reg && !iss_reg, "last while run active")
    `MAT4_ASSERT_SAME(a_no_issue_idle, clk, rst_n, iss_reg, busy_reg, "reads issued while idle")

endmodule

`default_nettype wire
